[hw/rtl/ljpe_pkg.sv]
// ljpe_pkg: shared constants and saturating helpers for the lennard-jones pair accumulator
// depends on nothing; imported by lj_pair_energy_virial_accumulator_unit
`timescale 1ns / 1ps
`default_nettype none
package ljpe_pkg;

   localparam int unsigned COEF_WIDTH = 32;
   localparam int unsigned SUM_WIDTH  = 64;
   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

   // returns {saturated, value}
   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, S64_MIN} : {1'b1, S64_MAX};
      end
      return {1'b0, s[63:0]};
   endfunction

   // magnitude and sign to signed 64, returns {saturated, value}
   function automatic logic [64:0] signed_of(input logic [63:0] mag, input logic neg);
      if (!neg) begin
         return mag[63] ? {1'b1, S64_MAX} : {1'b0, mag};
      end
      if (mag > S64_MIN) begin
         return {1'b1, S64_MIN};
      end
      return {1'b0, ~mag + 64'd1};
   endfunction

endpackage
`default_nettype wire

[hw/rtl/lj_pair_energy_virial_accumulator_unit.sv]
// lj_pair_energy_virial_accumulator_unit: truncated and shifted 12-6 pair energy and virial sums
// depends on ljpe_pkg
//
// usage: one neighbor pair per req transaction; req_tlast marks the last neighbor of an atom.
// after the last neighbor one rsp transaction carries the energy, the three virial sums and
// the sticky overflow flag, and the sums are cleared.
// csr_we/csr_wdata write the squared cutoff (unsigned q24.40); write it while idle.
// a counted pair takes 13 products on one shared 32x32 multiplier (four partial products each)
// and a restoring divider for the reciprocal of r^2; a pair at or beyond the cutoff stops
// after the three squares.
// req_tready is high only while the sequencer is idle.
// the result sits in an output register; a new pair is accepted while it waits, and a
// following result waits in the sequencer until rsp_tready frees the register.
// reset clears the sums, the flag, the cutoff and the output valid; the output data are not reset.
`timescale 1ns / 1ps
`default_nettype none
module lj_pair_energy_virial_accumulator_unit #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // disp_x, disp_y, disp_z, force_rep_coef, force_att_coef, energy_rep_coef,
   // energy_att_coef, energy_shift, zero pad
   input  wire logic [((3*COORD_WIDTH+5*ljpe_pkg::COEF_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // atom_energy, virial_x, virial_y, virial_z
   output logic [4*ljpe_pkg::SUM_WIDTH-1:0] rsp_tdata,
   // overflow_flag
   output logic               rsp_tuser,
   input  wire logic          csr_we,
   input  wire logic [63:0]   csr_wdata
);
   import ljpe_pkg::*;

   localparam int unsigned W   = COORD_WIDTH;
   localparam int unsigned OC1 = 3 * W;
   localparam int unsigned OC2 = OC1 + 32;
   localparam int unsigned OC3 = OC2 + 32;
   localparam int unsigned OC4 = OC3 + 32;
   localparam int unsigned OSH = OC4 + 32;

   localparam logic [3:0] OP_SQ0  = 4'd0;
   localparam logic [3:0] OP_SQ1  = 4'd1;
   localparam logic [3:0] OP_SQ2  = 4'd2;
   localparam logic [3:0] OP_R4I  = 4'd3;
   localparam logic [3:0] OP_R6I  = 4'd4;
   localparam logic [3:0] OP_AE   = 4'd5;
   localparam logic [3:0] OP_E    = 4'd6;
   localparam logic [3:0] OP_AF   = 4'd7;
   localparam logic [3:0] OP_F1   = 4'd8;
   localparam logic [3:0] OP_F    = 4'd9;
   localparam logic [3:0] OP_VX   = 4'd10;
   localparam logic [3:0] OP_VY   = 4'd11;
   localparam logic [3:0] OP_VZ   = 4'd12;
   localparam logic [2:0] PC_WB   = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_CHECK, S_DIV, S_ESH, S_ACC, S_DONE, S_EMIT
   } state_type;

   state_type   state_ff;
   logic [63:0] rcut_ff;
   logic [W-1:0] mag_ff [3];
   logic [31:0] c1_ff, c2_ff, c3_ff, c4_ff, sh_ff;
   logic        last_ff;
   logic [63:0] sq_ff [3];
   logic [63:0] r2_ff, rem_ff, q_ff, r2i_ff, t1_ff, r6i_ff, diffe_ff, difff_ff, term_ff;
   logic        nege_ff, negf_ff, sat_ff;
   logic [6:0]  bit_ff;
   logic [3:0]  op_ff;
   logic [2:0]  pc_ff;
   logic [63:0] pp_ff;
   logic [1:0]  ppsh_ff;
   logic [127:0] acc_ff;
   logic [63:0] energy_ff;
   logic [63:0] virial_ff [3];
   logic        sticky_ff;
   logic        rsp_tvalid_ff;
   logic [4*SUM_WIDTH-1:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   logic [63:0] opa, opb, mulres, sh64, aval, bval;
   logic [31:0] xa, xb;
   logic        mulovf;
   logic [65:0] sum66;
   logic        big;
   logic [63:0] r2;
   logic [64:0] remsh;
   logic        qbit;
   logic [1:0]  vidx;
   logic [64:0] addr;
   logic [W-1:0] dx [3];

   always_comb begin
      vidx = 2'(op_ff - OP_VX);
      case (op_ff) inside
         OP_SQ0, OP_SQ1, OP_SQ2: begin
            opa = 64'(mag_ff[op_ff[1:0]]);
            opb = 64'(mag_ff[op_ff[1:0]]);
         end
         OP_R4I: begin opa = r2i_ff; opb = r2i_ff; end
         OP_R6I: begin opa = t1_ff; opb = r2i_ff; end
         OP_AE:  begin opa = {16'd0, c3_ff, 16'd0}; opb = r6i_ff; end
         OP_E:   begin opa = r6i_ff; opb = diffe_ff; end
         OP_AF:  begin opa = {16'd0, c1_ff, 16'd0}; opb = r6i_ff; end
         OP_F1:  begin opa = r6i_ff; opb = r2i_ff; end
         OP_F:   begin opa = t1_ff; opb = difff_ff; end
         default: begin opa = t1_ff; opb = {8'd0, sq_ff[vidx][63:8]}; end
      endcase
      xa = pc_ff[1] ? opa[63:32] : opa[31:0];
      xb = pc_ff[0] ? opb[63:32] : opb[31:0];
      mulovf = |acc_ff[127:96];
      mulres = mulovf ? '1 : acc_ff[95:32];
      sum66 = {2'd0, sq_ff[0]} + {2'd0, sq_ff[1]} + {2'd0, sq_ff[2]};
      big = (|sum66[65:64]) || (|(64'(mag_ff[0]) >> 32)) || (|(64'(mag_ff[1]) >> 32))
            || (|(64'(mag_ff[2]) >> 32));
      r2 = big ? '1 : sum66[63:0];
      remsh = {rem_ff, bit_ff == 7'd72};
      qbit = remsh >= {1'b0, r2_ff};
      sh64 = {{16{sh_ff[31]}}, sh_ff, 16'd0};
      aval = mulres;
      bval = (op_ff == OP_AE) ? {16'd0, c4_ff, 16'd0} : {16'd0, c2_ff, 16'd0};
      addr = (op_ff == OP_E) ? sat_add(energy_ff, term_ff) : sat_add(virial_ff[vidx], term_ff);
      for (int k = 0; k < 3; k++) begin
         dx[k] = req_tdata[k*W +: W];
         dx[k] = dx[k][W-1] ? (~dx[k] + 1'b1) : dx[k];
      end
   end

   always_ff @(posedge clock) begin
      logic [64:0] so;
      if (reset) begin
         state_ff <= S_IDLE;
         rcut_ff <= '0;
         energy_ff <= '0;
         for (int k = 0; k < 3; k++) virial_ff[k] <= '0;
         sticky_ff <= 1'b0;
         sat_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         op_ff <= OP_SQ0;
         pc_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (csr_we) rcut_ff <= csr_wdata;
         if (state_ff == S_EMIT && (!rsp_tvalid_ff || rsp_tready)) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         if (pc_ff < 3'd4) begin
            pp_ff <= 64'(xa) * 64'(xb);
            ppsh_ff <= 2'(pc_ff[1]) + 2'(pc_ff[0]);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  for (int k = 0; k < 3; k++) mag_ff[k] <= dx[k];
                  c1_ff <= req_tdata[OC1 +: 32];
                  c2_ff <= req_tdata[OC2 +: 32];
                  c3_ff <= req_tdata[OC3 +: 32];
                  c4_ff <= req_tdata[OC4 +: 32];
                  sh_ff <= req_tdata[OSH +: 32];
                  last_ff <= req_tlast;
                  sat_ff <= 1'b0;
                  op_ff <= OP_SQ0;
                  pc_ff <= '0;
                  acc_ff <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (pc_ff != PC_WB) begin
                  pc_ff <= pc_ff + 3'd1;
                  if (pc_ff != 3'd0) acc_ff <= acc_ff + ({64'd0, pp_ff} << {ppsh_ff, 5'd0});
               end else begin
                  pc_ff <= '0;
                  acc_ff <= '0;
                  case (op_ff) inside
                     OP_SQ0, OP_SQ1, OP_SQ2: begin
                        sq_ff[op_ff[1:0]] <= acc_ff[63:0];
                        op_ff <= op_ff + 4'd1;
                        if (op_ff == OP_SQ2) state_ff <= S_CHECK;
                     end
                     OP_R4I, OP_F1, OP_F: begin
                        t1_ff <= mulres;
                        if (mulovf) sat_ff <= 1'b1;
                        op_ff <= op_ff + 4'd1;
                     end
                     OP_R6I: begin
                        r6i_ff <= mulres;
                        if (mulovf) sat_ff <= 1'b1;
                        op_ff <= op_ff + 4'd1;
                     end
                     OP_AE: begin
                        nege_ff <= aval < bval;
                        diffe_ff <= (aval < bval) ? bval - aval : aval - bval;
                        if (mulovf) sat_ff <= 1'b1;
                        op_ff <= op_ff + 4'd1;
                     end
                     OP_AF: begin
                        negf_ff <= aval < bval;
                        difff_ff <= (aval < bval) ? bval - aval : aval - bval;
                        if (mulovf) sat_ff <= 1'b1;
                        op_ff <= op_ff + 4'd1;
                     end
                     OP_E: begin
                        so = signed_of(mulres, nege_ff);
                        term_ff <= so[63:0];
                        if (mulovf || so[64]) sat_ff <= 1'b1;
                        state_ff <= S_ESH;
                     end
                     default: begin
                        so = signed_of(mulres, negf_ff);
                        term_ff <= so[63:0];
                        if (mulovf || so[64]) sat_ff <= 1'b1;
                        state_ff <= S_ACC;
                     end
                  endcase
               end
            end
            S_CHECK: begin
               if (!(r2 < rcut_ff)) begin
                  state_ff <= S_DONE;
               end else if (r2 == 64'd0) begin
                  sat_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else if (r2 <= 64'd256) begin
                  sat_ff <= 1'b1;
                  r2i_ff <= '1;
                  op_ff <= OP_R4I;
                  state_ff <= S_MUL;
               end else begin
                  r2_ff <= r2;
                  rem_ff <= '0;
                  q_ff <= '0;
                  bit_ff <= 7'd72;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= qbit ? 64'(remsh - {1'b0, r2_ff}) : remsh[63:0];
               q_ff <= {q_ff[62:0], qbit};
               bit_ff <= bit_ff - 7'd1;
               if (bit_ff == 7'd0) begin
                  r2i_ff <= {q_ff[62:0], qbit};
                  op_ff <= OP_R4I;
                  state_ff <= S_MUL;
               end
            end
            S_ESH: begin
               so = sat_add(term_ff, ~sh64 + 64'd1);
               term_ff <= so[63:0];
               if (so[64]) sat_ff <= 1'b1;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (addr[64]) sat_ff <= 1'b1;
               if (op_ff == OP_E) energy_ff <= addr[63:0];
               else virial_ff[vidx] <= addr[63:0];
               op_ff <= op_ff + 4'd1;
               state_ff <= (op_ff == OP_VZ) ? S_DONE : S_MUL;
            end
            S_DONE: begin
               if (sat_ff) sticky_ff <= 1'b1;
               sat_ff <= 1'b0;
               state_ff <= last_ff ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff <= {virial_ff[2], virial_ff[1], virial_ff[0], energy_ff};
                  rsp_tuser_ff <= sticky_ff;
                  energy_ff <= '0;
                  for (int k = 0; k < 3; k++) virial_ff[k] <= '0;
                  sticky_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (r2_ff > 64'd256)) else $error("divider started on small r^2");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_WB) else $error("partial product counter out of range");
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == S_EMIT))
      else $error("result dropped while output register full");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff) else $error("output valid after reset");

endmodule
`default_nettype wire
